>>> sv/ocl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ocl_pkg: shared types and constants of the orbit labeling block
// Sizes of the permutation table and the site layout, the input and result
// word formats, register indexes and the control group of the image cells.
// ----------------------------------------------------------------------------
package ocl_pkg;

    // Table depth, sites per labeling and bits kept of each label.
    localparam int MAX_PERMS  = 64;
    localparam int MAX_SITES  = 16;
    localparam int LABEL_BITS = 4;

    // The packed word layout: sixteen 4-bit nibbles, site 0 on top.
    localparam int NIB_BITS   = 4;
    localparam int NIB_COUNT  = 16;
    localparam int WORD_BITS  = NIB_BITS * NIB_COUNT;

    localparam int PERM_IDX_W = (MAX_PERMS > 1) ? $clog2(MAX_PERMS) : 1;
    localparam int COUNT_W    = 7;
    localparam int SITES_W    = 5;
    localparam int SLOT_W     = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PERM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT = 1'd1;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [SLOT_W-1:0]    perm_slot;
        logic [WORD_BITS-1:0] perm_row;
        logic [WORD_BITS-1:0] labeling;
    } in_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] canonical;
        logic                 superperiodic;
    } out_word_t;

    // Control shared by every cell of the image chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage : ocl_pkg
`default_nettype wire

>>> sv/ocl_permute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ocl_permute: applies one permutation row to a labeling
// Registered stage: image[k] = label[row[k]], with sites at or beyond the
// site count, and row entries that point at them, reading as zero.
// ----------------------------------------------------------------------------
module ocl_permute (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic                          in_last,
    input  wire logic [ocl_pkg::WORD_BITS-1:0] row,
    input  wire logic [ocl_pkg::WORD_BITS-1:0] labeling,
    input  wire logic [ocl_pkg::SITES_W-1:0]   sites,
    output logic                               out_valid,
    output logic                               out_last,
    output logic [ocl_pkg::WORD_BITS-1:0]      image
);
    import ocl_pkg::*;

    localparam logic [NIB_BITS-1:0] LABEL_MASK = NIB_BITS'((1 << LABEL_BITS) - 1);

    logic [NIB_BITS-1:0]  lab_nib [NIB_COUNT];
    logic [WORD_BITS-1:0] image_next;
    logic                 valid_reg;
    logic                 last_reg;
    logic [WORD_BITS-1:0] image_reg;

    always_comb begin
        logic [NIB_BITS-1:0] src;
        logic [NIB_BITS-1:0] val;
        image_next = '0;
        for (int k = 0; k < NIB_COUNT; k++) begin
            lab_nib[k] = labeling[WORD_BITS-NIB_BITS*(k+1) +: NIB_BITS];
        end
        for (int k = 0; k < NIB_COUNT; k++) begin
            src = row[WORD_BITS-NIB_BITS*(k+1) +: NIB_BITS];
            val = '0;
            if ((k < MAX_SITES) && (SITES_W'(k) < sites) && ({1'b0, src} < sites)) begin
                val = lab_nib[src] & LABEL_MASK;
            end
            image_next[WORD_BITS-NIB_BITS*(k+1) +: NIB_BITS] = val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            valid_reg <= in_valid;
            last_reg  <= in_valid & in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            image_reg <= image_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign image     = image_reg;

endmodule : ocl_permute
`default_nettype wire

>>> sv/ocl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ocl_cell: one cell of the image chain
// Holds one earlier image, compares it with each new image and keeps a
// sticky match flag; the held image moves on to the next cell on a shift.
// ----------------------------------------------------------------------------
module ocl_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ocl_pkg::cell_ctrl_t           ctrl,
    input  wire logic [ocl_pkg::WORD_BITS-1:0] bcast,
    input  wire logic [ocl_pkg::WORD_BITS-1:0] prev_image,
    input  wire logic                          prev_valid,
    output logic [ocl_pkg::WORD_BITS-1:0]      image,
    output logic                               valid,
    output logic                               hit
);
    import ocl_pkg::*;

    logic [WORD_BITS-1:0] image_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 hit_reg;
    logic                 hit_next;

    always_comb begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
            hit_next   = 1'b0;
        end else if (ctrl.shift) begin
            valid_next = prev_valid;
            hit_next   = hit_reg | (valid_reg & (image_reg == bcast));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            image_reg <= prev_image;
        end
    end

    assign image = image_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule : ocl_cell
`default_nettype wire

>>> sv/orbit_canonical_labeling.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orbit_canonical_labeling: canonical orbit representative of a labeling
// Loads permutation rows into a table and returns, for each labeling, the
// smallest permuted image and a flag for repeated images.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one permutation row into the table and gives
// no result. A classify word (mode 1) is applied to the first perm_count
// rows and yields one result word: the numerically smallest image,
// which is the lexicographically smallest labeling of the orbit, and the
// superperiodic flag. A classify word occupies the block until its result
// is loaded into the output register: the table has one read port, so one
// row is fetched, permuted and compared per cycle, and the flag is then
// gathered from the cells. The next word is taken as soon as the block is back
// in idle, even while the last result word still waits in the output
// register. Each new image is compared against every earlier image of the
// same word by a chain of cells: every cell holds one earlier image and
// passes it on to its neighbor as the next image arrives. Reading a table row
// that was never loaded gives an undefined image.
// ----------------------------------------------------------------------------
module orbit_canonical_labeling (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [ocl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ocl_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire ocl_pkg::in_word_t              s_data,
    // result words
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ocl_pkg::out_word_t                  m_data
);
    import ocl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam int GROUP  = 8;
    localparam int NGROUP = (MAX_PERMS + GROUP - 1) / GROUP;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] perm_count_reg;
    logic [SITES_W-1:0] site_count_reg;
    logic [COUNT_W-1:0] np_sat;
    logic [SITES_W-1:0] ns_sat;

    logic [COUNT_W-1:0]    np_reg;
    logic [SITES_W-1:0]    ns_reg;
    logic [WORD_BITS-1:0]  lab_reg;
    logic [PERM_IDX_W-1:0] issue_reg;
    logic                  issue_last;

    logic [WORD_BITS-1:0] perm_mem [MAX_PERMS];
    logic [WORD_BITS-1:0] row_reg;
    logic                 rd_vld_reg;
    logic                 rd_last_reg;

    logic                 img_vld;
    logic                 img_last;
    logic [WORD_BITS-1:0] img;

    logic [WORD_BITS-1:0] min_reg;
    logic                 first_reg;
    logic                 last_d1_reg;

    cell_ctrl_t           cell_ctrl;
    logic [WORD_BITS-1:0] chain_image [MAX_PERMS];
    logic                 chain_valid [MAX_PERMS];
    logic [MAX_PERMS-1:0] cell_hit;
    logic [NGROUP-1:0]    grp_reg;
    logic [NGROUP-1:0]    grp_next;

    logic                 m_valid_reg;
    out_word_t            m_data_reg;

    logic in_fire;
    logic load_fire;
    logic cls_fire;
    logic out_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid & s_ready;
    assign load_fire = in_fire & (s_data.mode == MODE_LOAD);
    assign cls_fire  = in_fire & (s_data.mode == MODE_CLASSIFY);
    assign out_load  = (state_reg == ST_FINISH) & (~m_valid_reg | m_ready);

    // Register values outside their ranges are saturated when a word starts.
    always_comb begin
        if (perm_count_reg == '0) begin
            np_sat = COUNT_W'(1);
        end else if (int'(perm_count_reg) > MAX_PERMS) begin
            np_sat = COUNT_W'(MAX_PERMS);
        end else begin
            np_sat = perm_count_reg;
        end
        if (site_count_reg == '0) begin
            ns_sat = SITES_W'(1);
        end else if (int'(site_count_reg) > MAX_SITES) begin
            ns_sat = SITES_W'(MAX_SITES);
        end else begin
            ns_sat = site_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_count_reg <= COUNT_W'(1);
            site_count_reg <= SITES_W'(16);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PERM_COUNT: perm_count_reg <= cfg_data[COUNT_W-1:0];
                REG_SITE_COUNT: site_count_reg <= cfg_data[SITES_W-1:0];
                default: ;
            endcase
        end
    end

    assign issue_last = (COUNT_W'(issue_reg) == np_reg - COUNT_W'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (cls_fire) state_next = ST_RUN;
            ST_RUN:    if (issue_last) state_next = ST_DRAIN;
            ST_DRAIN:  if (last_d1_reg) state_next = ST_FINISH;
            ST_FINISH: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            last_d1_reg <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= (state_reg == ST_RUN);
            rd_last_reg <= (state_reg == ST_RUN) & issue_last;
            last_d1_reg <= img_last;
            if (cls_fire) begin
                issue_reg <= '0;
                first_reg <= 1'b1;
            end else begin
                if (state_reg == ST_RUN) begin
                    issue_reg <= issue_reg + PERM_IDX_W'(1);
                end
                if (img_vld) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    // Word parameters are captured as the classify word is taken.
    always_ff @(posedge aclk) begin
        if (cls_fire) begin
            np_reg  <= np_sat;
            ns_reg  <= ns_sat;
            lab_reg <= s_data.labeling;
        end
    end

    // Permutation table: written by load words, read once per cycle in a run.
    always_ff @(posedge aclk) begin
        if (load_fire && (int'(s_data.perm_slot) < MAX_PERMS)) begin
            perm_mem[PERM_IDX_W'(s_data.perm_slot)] <= s_data.perm_row;
        end
        if (state_reg == ST_RUN) begin
            row_reg <= perm_mem[issue_reg];
        end
    end

    ocl_permute u_permute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_vld_reg),
        .in_last   (rd_last_reg),
        .row       (row_reg),
        .labeling  (lab_reg),
        .sites     (ns_reg),
        .out_valid (img_vld),
        .out_last  (img_last),
        .image     (img)
    );

    // Running minimum; the first image of a word always takes it.
    always_ff @(posedge aclk) begin
        if (img_vld && (first_reg || (img < min_reg))) begin
            min_reg <= img;
        end
    end

    // Chain of cells holding the earlier images of the current word. The
    // newest image is broadcast to all cells and enters cell 0 behind them.
    assign cell_ctrl.clear = cls_fire;
    assign cell_ctrl.shift = img_vld;

    for (genvar c = 0; c < MAX_PERMS; c++) begin : g_cell
        if (c == 0) begin : g_head
            ocl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .bcast      (img),
                .prev_image (img),
                .prev_valid (1'b1),
                .image      (chain_image[c]),
                .valid      (chain_valid[c]),
                .hit        (cell_hit[c])
            );
        end else begin : g_body
            ocl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .bcast      (img),
                .prev_image (chain_image[c-1]),
                .prev_valid (chain_valid[c-1]),
                .image      (chain_image[c]),
                .valid      (chain_valid[c]),
                .hit        (cell_hit[c])
            );
        end
    end

    // Match flags are gathered in groups of eight and registered.
    always_comb begin
        grp_next = '0;
        for (int g = 0; g < NGROUP; g++) begin
            for (int i = 0; i < GROUP; i++) begin
                if (g * GROUP + i < MAX_PERMS) begin
                    grp_next[g] = grp_next[g] | cell_hit[g * GROUP + i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg <= '0;
        end else begin
            grp_reg <= grp_next;
        end
    end

    // Output register: the result waits here while the next word is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.canonical     <= min_reg;
            m_data_reg.superperiodic <= |grp_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The row counter never passes the number of rows in use.
    a_issue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (COUNT_W'(issue_reg) < np_reg))
        else $error("row counter beyond the rows in use");

    // No new word is taken while images still move through the chain.
    a_busy_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (img_vld || rd_vld_reg) |-> !s_ready)
        else $error("input taken while images are in flight");

    // A result only appears after the flag has been gathered.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word without a finished classify");

endmodule : orbit_canonical_labeling
`default_nettype wire
